// ----- rtl/mini_printf_formatter_core_assert.svh -----
// assertion macros for the formatter checker
// expects i_clk and i_rst_n in the scope of use
`ifndef MINI_PRINTF_FORMATTER_CORE_ASSERT_SVH
`define MINI_PRINTF_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define MPF_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPF_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mpf_pkg.sv -----
// constants, character codes and widths for the mini printf formatter
// no dependencies
package mpf_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int MAX_RESULTS = 19;

    localparam int TOTAL_W    = 16;
    localparam int BIN_W      = 32;
    localparam int INT_DIGITS = 10;
    localparam int BCD_W      = 4 * INT_DIGITS;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int DIG_W      = $clog2(INT_DIGITS);
    localparam int FI_W       = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
    localparam int NRES_W     = $clog2(MAX_RESULTS);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NUL     = 8'h00;

endpackage

// ----- rtl/mini_printf_formatter_core.sv -----
// Mini printf formatter: one format byte per input beat, characters out one per beat.
// A plain byte, %c or an end beat keeps the input stalled after it is taken, until its
// output beat is sent; a lone '%' is taken with no result.
// %d and %f run a shift-and-add-3 BCD conversion of the 32-bit integer magnitude, then
// send a minus sign if negative and step through the ten digit positions, one per cycle
// while the output is not stalled, whether a leading zero is skipped or a digit is sent;
// %f adds the point and six fraction digits (one multiply-by-ten step each).
// Output stalls hold the sequencer; a new beat is taken once it is idle.
module mini_printf_formatter_core
    import mpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_fmt_byte,
    input  logic                i_end_of_format,
    input  logic signed [31:0]  i_int_arg,
    input  logic signed [63:0]  i_fixed_arg,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_char,
    output logic                o_char_valid,
    output logic [TOTAL_W-1:0]  o_char_total,
    output logic                o_run_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_ONE, S_END, S_SIGN, S_INT, S_DOT, S_FRAC
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_ap, n_ap;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_is_fix, n_is_fix;
    logic                   r_neg, n_neg;
    logic                   r_lead, n_lead;
    logic [7:0]             r_byte, n_byte;
    logic [BIN_W-1:0]       r_bin, n_bin;
    logic [BIN_W-1:0]       r_frac, n_frac;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIG_W-1:0]       r_dig, n_dig;
    logic [FI_W-1:0]        r_fi, n_fi;
    logic [NRES_W-1:0]      r_nres, n_nres;

    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_ochar, n_ochar;
    logic                   r_ocv, n_ocv;
    logic [TOTAL_W-1:0]     r_ototal, n_ototal;
    logic                   r_olast, n_olast;

    logic                   acc, slot_free;
    logic                   e_fire, e_cv, e_last;
    logic [7:0]             e_char;
    logic [3:0]             cur_dig;
    logic [BCD_W-1:0]       adj;
    logic [BIN_W+3:0]       prod;
    logic [63:0]            fix_mag;
    logic [BIN_W-1:0]       int_mag;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign o_stall   = (r_state != S_IDLE);
    assign acc       = i_valid && !o_stall;
    assign slot_free = !r_ovalid || !i_stall;

    assign o_valid      = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_char_valid = r_ocv;
    assign o_char_total = r_ototal;
    assign o_run_last   = r_olast;

    assign cur_dig = r_bcd[4*r_dig +: 4];
    assign prod    = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign fix_mag = i_fixed_arg[63] ? (~i_fixed_arg + 64'd1) : i_fixed_arg;
    assign int_mag = i_int_arg[31] ? (~i_int_arg + 32'd1) : i_int_arg;
    assign cnt_inc = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    always_comb begin
        for (int k = 0; k < INT_DIGITS; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        e_fire = 1'b0;
        e_cv   = 1'b1;
        e_last = 1'b0;
        e_char = CH_NUL;
        unique case (r_state)
            S_ONE: begin
                e_fire = slot_free;
                e_char = r_byte;
                e_last = 1'b1;
            end
            S_END: begin
                e_fire = slot_free;
                e_cv   = 1'b0;
                e_last = 1'b1;
            end
            S_SIGN: begin
                e_fire = slot_free;
                e_char = CH_MINUS;
            end
            S_INT: begin
                e_fire = slot_free && !(r_lead && cur_dig == 4'd0 && r_dig != '0);
                e_char = CH_ZERO + {4'b0000, cur_dig};
                e_last = (r_dig == '0) && !r_is_fix;
            end
            S_DOT: begin
                e_fire = slot_free;
                e_char = CH_DOT;
            end
            S_FRAC: begin
                e_fire = slot_free;
                e_char = CH_ZERO + {4'b0000, prod[BIN_W+3:BIN_W]};
                e_last = (r_fi == FI_W'(FRAC_DIGITS - 1));
            end
            default: begin
                e_fire = 1'b0;
            end
        endcase
        if (r_nres == NRES_W'(MAX_RESULTS - 1)) begin
            e_last = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ap     = r_ap;
        n_count  = r_count;
        n_is_fix = r_is_fix;
        n_neg    = r_neg;
        n_lead   = r_lead;
        n_byte   = r_byte;
        n_bin    = r_bin;
        n_frac   = r_frac;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_fi     = r_fi;
        n_nres   = r_nres;
        n_ovalid = r_ovalid && i_stall;
        n_ochar  = r_ochar;
        n_ocv    = r_ocv;
        n_ototal = r_ototal;
        n_olast  = r_olast;

        if (acc) begin
            n_nres = '0;
            n_bcd  = '0;
            n_cnt  = '0;
            n_dig  = DIG_W'(INT_DIGITS - 1);
            n_fi   = '0;
            n_lead = 1'b1;
            n_byte = i_fmt_byte;
            n_ap   = 1'b0;
            if (i_end_of_format) begin
                n_state = S_END;
            end else if (r_ap) begin
                priority if (i_fmt_byte == CH_D) begin
                    n_state  = S_CONV;
                    n_is_fix = 1'b0;
                    n_neg    = i_int_arg[31];
                    n_bin    = int_mag;
                end else if (i_fmt_byte == CH_C) begin
                    n_state = S_ONE;
                    n_byte  = i_int_arg[7:0];
                end else if (i_fmt_byte == CH_F) begin
                    n_state  = S_CONV;
                    n_is_fix = 1'b1;
                    n_neg    = i_fixed_arg[63];
                    n_bin    = fix_mag[63:32];
                    n_frac   = fix_mag[31:0];
                end else begin
                    n_state = S_ONE;
                end
            end else if (i_fmt_byte == CH_PERCENT) begin
                n_ap = 1'b1;
            end else begin
                n_state = S_ONE;
            end
        end

        if (r_state == S_CONV) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[BIN_W-1]};
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(BIN_W - 1)) begin
                n_state = r_neg ? S_SIGN : S_INT;
            end
        end

        if (r_state == S_INT && !e_fire && !(r_ovalid && i_stall)) begin
            n_dig = r_dig - 1'b1;
        end

        if (e_fire) begin
            n_ovalid = 1'b1;
            n_ochar  = e_char;
            n_ocv    = e_cv;
            n_olast  = e_last;
            n_nres   = r_nres + 1'b1;
            if (e_cv) begin
                n_count  = cnt_inc;
                n_ototal = TOTAL_W'(cnt_inc);
            end else begin
                n_count  = '0;
                n_ototal = TOTAL_W'(r_count);
            end
            unique case (r_state)
                S_SIGN: n_state = S_INT;
                S_INT: begin
                    n_lead = 1'b0;
                    n_dig  = r_dig - 1'b1;
                    if (r_dig == '0) begin
                        n_state = S_DOT;
                    end
                end
                S_DOT: n_state = S_FRAC;
                S_FRAC: begin
                    n_frac = prod[BIN_W-1:0];
                    n_fi   = r_fi + 1'b1;
                end
                default: n_state = S_IDLE;
            endcase
            if (e_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ap     <= 1'b0;
            r_count  <= '0;
            r_nres   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ap     <= n_ap;
            r_count  <= n_count;
            r_nres   <= n_nres;
            r_ovalid <= n_ovalid;
        end
        r_is_fix <= n_is_fix;
        r_neg    <= n_neg;
        r_lead   <= n_lead;
        r_byte   <= n_byte;
        r_bin    <= n_bin;
        r_frac   <= n_frac;
        r_bcd    <= n_bcd;
        r_cnt    <= n_cnt;
        r_dig    <= n_dig;
        r_fi     <= n_fi;
        r_ochar  <= n_ochar;
        r_ocv    <= n_ocv;
        r_ototal <= n_ototal;
        r_olast  <= n_olast;
    end

endmodule

// ----- rtl/mpf_checker.sv -----
// port-level checks for the mini printf formatter, bound to the top level
// depends on mpf_pkg and mini_printf_formatter_core_assert.svh
`include "mini_printf_formatter_core_assert.svh"

module mpf_checker
    import mpf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [7:0]          i_fmt_byte,
    input logic                i_end_of_format,
    input logic signed [31:0]  i_int_arg,
    input logic signed [63:0]  i_fixed_arg,
    input logic                o_valid,
    input logic                i_stall,
    input logic [7:0]          o_out_char,
    input logic                o_char_valid,
    input logic [TOTAL_W-1:0]  o_char_total,
    input logic                o_run_last
);

    // stalled output beat holds
    `MPF_AST_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_char) && $stable(o_char_total) && $stable(o_run_last), "stalled output beat changed")

    // count beat is the last of its item and carries no character
    `MPF_AST_SAME(a_count_beat, o_valid && !o_char_valid, o_run_last && o_out_char == CH_NUL, "count beat malformed")

    // a character beat always has a non-zero running total
    `MPF_AST_SAME(a_total_nz, o_valid && o_char_valid, o_char_total != '0, "character beat with zero total")

    // an end beat always occupies the sequencer
    `MPF_AST_NEXT(a_end_busy, i_valid && !o_stall && i_end_of_format, o_stall, "end beat not held")

endmodule

bind mini_printf_formatter_core mpf_checker u_mpf_checker (.*);
